/* hw/rtl/asd_pkg.sv */
`default_nettype none
package asd_pkg;

    localparam int MAX_ITEMS = 32;
    localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int VAL_W     = 16;

    localparam logic [1:0] CMD_LOAD_A = 2'd0;
    localparam logic [1:0] CMD_LOAD_B = 2'd1;
    localparam logic [1:0] CMD_RUN    = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_CMP,
        S_FOUND,
        S_FINAL
    } t_state;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic start;
        logic next_phase;
        logic j_inc;
        logic next_item;
        logic take_pend;
        logic push_pend;
        logic push_final;
    } t_dp_cmd;

    typedef struct packed {
        logic i_done;
        logic j_past;
        logic match;
        logic pend_valid;
        logic out_free;
        logic sym;
        logic phase;
    } t_dp_stat;

endpackage
`default_nettype wire

/* hw/rtl/asd_ram.sv */
`default_nettype none
module asd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                            i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* hw/rtl/asd_ctrl.sv */
`default_nettype none
module asd_ctrl
    import asd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_cmd,
    input  wire t_dp_stat   i_stat,
    output logic            o_in_ready,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_cmd == CMD_RUN) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_stat.i_done) begin
                    n_state = S_CMP;
                end else if (i_stat.phase || !i_stat.sym) begin
                    n_state = S_FINAL;
                end
            end
            S_CMP: begin
                priority if (i_stat.match) begin
                    n_state = S_CHECK;
                end else if (i_stat.j_past) begin
                    n_state = S_FOUND;
                end
            end
            S_FOUND: begin
                if (!i_stat.pend_valid || i_stat.out_free) begin
                    n_state = S_CHECK;
                end
            end
            S_FINAL: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_a = (i_cmd == CMD_LOAD_A);
                    o_cmd.load_b = (i_cmd == CMD_LOAD_B);
                    o_cmd.start  = (i_cmd == CMD_RUN);
                end
            end
            S_CHECK: begin
                if (!i_stat.i_done) begin
                    o_cmd.j_inc = 1'b1;
                end else if (!i_stat.phase && i_stat.sym) begin
                    o_cmd.next_phase = 1'b1;
                end
            end
            S_CMP: begin
                priority if (i_stat.match) begin
                    o_cmd.next_item = 1'b1;
                end else if (!i_stat.j_past) begin
                    o_cmd.j_inc = 1'b1;
                end
            end
            S_FOUND: begin
                if (!i_stat.pend_valid || i_stat.out_free) begin
                    o_cmd.take_pend = 1'b1;
                    o_cmd.push_pend = i_stat.pend_valid;
                    o_cmd.next_item = 1'b1;
                end
            end
            S_FINAL: begin
                o_cmd.push_final = i_stat.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

/* hw/rtl/asd_dp.sv */
`default_nettype none
module asd_dp
    import asd_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic                    i_cfg_wdata,
    input  wire logic signed [VAL_W-1:0] i_value,
    input  wire t_dp_cmd                 i_cmd,
    input  wire logic                    i_out_ready,
    output t_dp_stat                     o_stat,
    output logic                         o_out_valid,
    output logic signed [VAL_W-1:0]      o_value_res,
    output logic                         o_from_b,
    output logic                         o_none,
    output logic                         o_last
);

    logic             r_sym;
    logic [CNT_W-1:0] r_cnt_a;
    logic [CNT_W-1:0] r_cnt_b;
    logic [CNT_W-1:0] r_i;
    logic [CNT_W-1:0] r_j;
    logic             r_phase;

    logic             r_pend_valid;
    logic [VAL_W-1:0] r_pend_value;
    logic             r_pend_from_b;

    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_value;
    logic             r_out_from_b;
    logic             r_out_none;
    logic             r_out_last;

    logic             wr_a;
    logic             wr_b;
    logic [IDX_W-1:0] addr_a;
    logic [IDX_W-1:0] addr_b;
    logic [VAL_W-1:0] q_a;
    logic [VAL_W-1:0] q_b;
    logic [VAL_W-1:0] q_outer;
    logic [VAL_W-1:0] q_inner;
    logic [CNT_W-1:0] cnt_outer;
    logic [CNT_W-1:0] cnt_inner;
    logic             out_free;

    assign wr_a = i_cmd.load_a && (r_cnt_a < CNT_W'(MAX_ITEMS));
    assign wr_b = i_cmd.load_b && (r_cnt_b < CNT_W'(MAX_ITEMS));

    assign addr_a = r_phase ? r_j[IDX_W-1:0] : r_i[IDX_W-1:0];
    assign addr_b = r_phase ? r_i[IDX_W-1:0] : r_j[IDX_W-1:0];

    asd_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ITEMS)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (wr_a),
        .i_waddr (r_cnt_a[IDX_W-1:0]),
        .i_wdata (i_value),
        .i_raddr (addr_a),
        .o_rdata (q_a)
    );

    asd_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ITEMS)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (wr_b),
        .i_waddr (r_cnt_b[IDX_W-1:0]),
        .i_wdata (i_value),
        .i_raddr (addr_b),
        .o_rdata (q_b)
    );

    assign q_outer   = r_phase ? q_b : q_a;
    assign q_inner   = r_phase ? q_a : q_b;
    assign cnt_outer = r_phase ? r_cnt_b : r_cnt_a;
    assign cnt_inner = r_phase ? r_cnt_a : r_cnt_b;
    assign out_free  = !r_out_valid || i_out_ready;

    // inner RAM data lags r_j by one: it holds entry r_j - 1
    always_comb begin
        o_stat            = '0;
        o_stat.i_done     = (r_i == cnt_outer);
        o_stat.j_past     = (r_j >= cnt_inner);
        o_stat.match      = (r_j <= cnt_inner) && (q_outer == q_inner);
        o_stat.pend_valid = r_pend_valid;
        o_stat.out_free   = out_free;
        o_stat.sym        = r_sym;
        o_stat.phase      = r_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym        <= 1'b1;
            r_cnt_a      <= '0;
            r_cnt_b      <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_phase      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_sym <= i_cfg_wdata;
            end
            if (wr_a) begin
                r_cnt_a <= r_cnt_a + 1'b1;
            end
            if (wr_b) begin
                r_cnt_b <= r_cnt_b + 1'b1;
            end
            if (i_cmd.start || i_cmd.next_phase) begin
                r_i     <= '0;
                r_j     <= '0;
                r_phase <= i_cmd.next_phase;
            end
            if (i_cmd.j_inc) begin
                r_j <= r_j + 1'b1;
            end
            if (i_cmd.next_item) begin
                r_i <= r_i + 1'b1;
                r_j <= '0;
            end
            if (i_cmd.take_pend) begin
                r_pend_valid <= 1'b1;
            end
            if (i_cmd.push_pend || i_cmd.push_final) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.push_final) begin
                r_pend_valid <= 1'b0;
                r_cnt_a      <= '0;
                r_cnt_b      <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_pend) begin
            r_pend_value  <= q_outer;
            r_pend_from_b <= r_phase;
        end
        if (i_cmd.push_pend) begin
            r_out_value  <= r_pend_value;
            r_out_from_b <= r_pend_from_b;
            r_out_none   <= 1'b0;
            r_out_last   <= 1'b0;
        end else if (i_cmd.push_final) begin
            r_out_value  <= r_pend_valid ? r_pend_value : '0;
            r_out_from_b <= r_pend_valid && r_pend_from_b;
            r_out_none   <= !r_pend_valid;
            r_out_last   <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value_res = r_out_value;
    assign o_from_b    = r_out_from_b;
    assign o_none      = r_out_none;
    assign o_last      = r_out_last;

endmodule
`default_nettype wire

/* hw/rtl/array_symmetric_difference_top.sv */
// Two lists A and B of signed 16-bit values, up to MAX_ITEMS each.
// Input channel (i_in_valid / o_in_ready): i_cmd 0 appends i_value to A,
// 1 appends to B, 2 runs; cmd 3 is dropped. Loads into a full list are
// dropped. Loads take one beat per cycle while no run is in progress.
// A run emits on the output channel (o_out_valid / i_out_ready) every
// element of A absent from B, then, with symmetric mode set, every
// element of B absent from A. o_last marks the final beat; an empty
// answer is a single beat with o_none and o_last set. Both counts clear.
// The input is not ready during a run. Per outer element the scan has a
// check step, then compares the inner entries one at a time up to the
// first match (at least one compare), then a found step if the element
// is emitted; the pace is set by the single read port of each list RAM.
// A stalled receiver holds the output register and pauses the scan
// once one further result is pending.
// Reset (i_rst_n low, synchronous) empties both lists, drops any run in
// progress and sets symmetric mode. i_cfg_we writes the mode bit.
`default_nettype none
module array_symmetric_difference_top
    import asd_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic                    i_cfg_wdata,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [1:0]              i_cmd,
    input  wire logic signed [VAL_W-1:0] i_value,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic signed [VAL_W-1:0]      o_value_res,
    output logic                         o_from_b,
    output logic                         o_none,
    output logic                         o_last
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    asd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_stat     (dp_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (dp_cmd)
    );

    asd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_value     (i_value),
        .i_cmd       (dp_cmd),
        .i_out_ready (i_out_ready),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .o_value_res (o_value_res),
        .o_from_b    (o_from_b),
        .o_none      (o_none),
        .o_last      (o_last)
    );

endmodule
`default_nettype wire

/* hw/rtl/asd_checker.sv */
`default_nettype none
module asd_checker
    import asd_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_in_valid,
    input wire logic                    o_in_ready,
    input wire logic [1:0]              i_cmd,
    input wire logic                    o_out_valid,
    input wire logic                    i_out_ready,
    input wire logic signed [VAL_W-1:0] o_value_res,
    input wire logic                    o_from_b,
    input wire logic                    o_none,
    input wire logic                    o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_value_res)
            && $stable(o_from_b) && $stable(o_none) && $stable(o_last))
        else $error("output beat changed while stalled");

    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_none |-> o_last)
        else $error("empty answer beat not marked last");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_none |-> o_value_res == '0 && !o_from_b)
        else $error("empty answer beat carries data");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_cmd == CMD_RUN |=> !o_in_ready)
        else $error("input ready right after a run beat");

endmodule

bind array_symmetric_difference_top asd_checker u_asd_checker (.*);
`default_nettype wire
